>>> src/nga_pkg.sv
package nga_pkg;

	// Kinds of word passed from the front to the back.
	typedef enum logic [1:0] {
		TK_START,
		TK_CHAR,
		TK_COMMIT,
		TK_EMIT
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  data;
		logic [3:0]  field;
		logic [3:0]  cif;
	} token_t;

	// Field numbers inside a GGA sentence.
	localparam logic [3:0] FLD_TIME = 4'd1;
	localparam logic [3:0] FLD_LAT  = 4'd2;
	localparam logic [3:0] FLD_NS   = 4'd3;
	localparam logic [3:0] FLD_LON  = 4'd4;
	localparam logic [3:0] FLD_EW   = 4'd5;
	localparam logic [3:0] FLD_SATS = 4'd7;
	localparam logic [3:0] FLD_ALT  = 4'd9;
	localparam logic [3:0] FLD_UNIT = 4'd10;
	localparam logic [3:0] FLD_MAX  = 4'd15;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] UNIT_OFS  = 8'h20;

	localparam logic [29:0] COORD_MAX = 30'd999999999;
	localparam logic [24:0] ALT_MAX   = 25'd9999999;
	localparam logic [31:0] ACC_STUCK = 32'hFFFF_FFFF;
	localparam logic [2:0]  COORD_OUT = 3'd4;
	localparam logic [2:0]  ALT_OUT   = 3'd1;

	// Expected header character at a match position.
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h47;
			3'd4: c = 8'h47;
			3'd5: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Powers of ten used to scale a value up by up to four digits.
	function automatic logic [13:0] pow10(input logic [2:0] k);
		logic [13:0] p;
		case (k)
			3'd0: p = 14'd1;
			3'd1: p = 14'd10;
			3'd2: p = 14'd100;
			3'd3: p = 14'd1000;
			3'd4: p = 14'd10000;
			default: p = 14'd1;
		endcase
		return p;
	endfunction

	// Exact quotient by ten for any 32-bit value, by reciprocal.
	function automatic logic [31:0] div10(input logic [31:0] x);
		logic [63:0] p;
		p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
		return {3'd0, p[63:35]};
	endfunction

	// Exact quotient by one hundred for any 32-bit value, by reciprocal.
	function automatic logic [31:0] div100(input logic [31:0] x);
		logic [63:0] p;
		p = {32'd0, x} * 64'h0000_0000_51EB_851F;
		return {5'd0, p[63:37]};
	endfunction

endpackage

>>> src/nga_byte_if.sv
interface nga_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/nga_fix_if.sv
interface nga_fix_if;
	logic        valid;
	logic        ready;
	logic [6:0]  utc_hour;
	logic [6:0]  utc_minute;
	logic [6:0]  utc_second;
	logic [29:0] latitude_scaled;
	logic [7:0]  lat_hemisphere;
	logic [29:0] longitude_scaled;
	logic [7:0]  lon_hemisphere;
	logic [7:0]  satellite_count;
	logic signed [24:0] altitude_tenths;
	logic [7:0]  altitude_unit;

	modport source (output valid, output utc_hour, output utc_minute, output utc_second,
		output latitude_scaled, output lat_hemisphere, output longitude_scaled,
		output lon_hemisphere, output satellite_count, output altitude_tenths,
		output altitude_unit, input ready);
	modport sink (input valid, input utc_hour, input utc_minute, input utc_second,
		input latitude_scaled, input lat_hemisphere, input longitude_scaled,
		input lon_hemisphere, input satellite_count, input altitude_tenths,
		input altitude_unit, output ready);
endinterface

>>> src/nga_front.sv
module nga_front (
	input  logic            clk,
	input  logic            arst_n,
	nga_byte_if.sink        rx,
	input  logic            tok_full,
	output logic            tok_push,
	output nga_pkg::token_t tok
);

	logic [2:0] hdr_q, hdr_d;
	logic       gga_q, gga_d;
	logic [3:0] field_q, field_d;
	logic [3:0] cif_q, cif_d;
	logic       acc;
	logic [7:0] b;

	assign rx.ready = !tok_full;
	assign acc = rx.valid && rx.ready;
	assign b = rx.rx_byte;

	// Sentence tracking and word generation for each accepted byte.
	always_comb begin
		hdr_d = hdr_q;
		gga_d = gga_q;
		field_d = field_q;
		cif_d = cif_q;
		tok_push = 1'b0;
		tok.kind = nga_pkg::TK_CHAR;
		tok.data = b;
		tok.field = field_q;
		tok.cif = cif_q;
		if (acc) begin
			if (b == nga_pkg::CH_DOLLAR) begin
				hdr_d = 3'd1;
				gga_d = 1'b0;
				field_d = 4'd0;
				cif_d = 4'd0;
			end else if (b == nga_pkg::CH_CR || b == nga_pkg::CH_LF) begin
				tok_push = gga_q;
				tok.kind = nga_pkg::TK_EMIT;
				hdr_d = 3'd0;
				gga_d = 1'b0;
				field_d = 4'd0;
				cif_d = 4'd0;
			end else if (gga_q) begin
				tok_push = 1'b1;
				if (b == nga_pkg::CH_COMMA) begin
					tok.kind = nga_pkg::TK_COMMIT;
					if (field_q != nga_pkg::FLD_MAX)
						field_d = field_q + 4'd1;
					cif_d = 4'd0;
				end else begin
					if (cif_q != 4'd15)
						cif_d = cif_q + 4'd1;
				end
			end else if (hdr_q >= 3'd1 && hdr_q <= 3'd5) begin
				hdr_d = (b == nga_pkg::hdr_char(hdr_q)) ? hdr_q + 3'd1 : 3'd0;
			end else if (hdr_q == 3'd6 && b == nga_pkg::CH_COMMA) begin
				tok_push = 1'b1;
				tok.kind = nga_pkg::TK_START;
				gga_d = 1'b1;
				field_d = nga_pkg::FLD_TIME;
				hdr_d = 3'd0;
				cif_d = 4'd0;
			end else begin
				hdr_d = 3'd0;
			end
		end
	end

	// Front state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= 3'd0;
			gga_q <= 1'b0;
			field_q <= 4'd0;
			cif_q <= 4'd0;
		end else begin
			hdr_q <= hdr_d;
			gga_q <= gga_d;
			field_q <= field_d;
			cif_q <= cif_d;
		end
	end

endmodule

>>> src/nga_fifo.sv
module nga_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nga_pkg::token_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output nga_pkg::token_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

	nga_pkg::token_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == FULLCNT);
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	// Storage; entries hold no reset value.
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
			if (do_pop)
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("word pushed into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !valid))
		else $error("word popped from an empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULLCNT)
		else $error("queue count beyond its depth");

endmodule

>>> src/nga_back.sv
module nga_back #(
	parameter int COORD_FRAC_DIGITS = 4,
	parameter int ALT_FRAC_DIGITS = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	input  nga_pkg::token_t tok,
	output logic            tok_pop,
	nga_fix_if.source       fix
);

	localparam logic [2:0] COORD_LIM = 3'(COORD_FRAC_DIGITS);
	localparam logic [2:0] ALT_LIM = 3'(ALT_FRAC_DIGITS);

	logic adv;

	// Field accumulator state.
	logic [31:0] acc_q;
	logic [2:0]  frac_q;
	logic        point_q, neg_q;

	// Stage one: snapshot of the word and of the accumulator.
	logic                v_s1;
	nga_pkg::tok_kind_t  kind_s1;
	logic [7:0]          data_s1;
	logic [3:0]          field_s1, cif_s1;
	logic [31:0]         acc_s1;
	logic [2:0]          frac_s1;
	logic                neg_s1;

	// Stage two: scaled magnitude.
	logic                v_s2;
	nga_pkg::tok_kind_t  kind_s2;
	logic [7:0]          data_s2;
	logic [3:0]          field_s2, cif_s2;
	logic [45:0]         mag_s2;
	logic                stuck_s2, neg_s2;

	// Stored values.
	logic [3:0]  tdig_q [6];
	logic [29:0] lat_q, lon_q;
	logic [7:0]  ns_q, ew_q, unit_q, sats_q;
	logic [24:0] alt_q;

	logic [3:0]  tdig_d [6];
	logic [29:0] lat_d, lon_d;
	logic [7:0]  ns_d, ew_d, unit_d, sats_d;
	logic [24:0] alt_d;

	logic out_v_q;

	assign adv = !out_v_q || fix.ready;
	assign tok_pop = adv && tok_valid;

	// Digit accumulation with sticky saturation.
	logic        is_num, is_digit, take_digit;
	logic [2:0]  lim;
	logic [3:0]  dval;
	logic [35:0] prod10;
	logic [31:0] acc_d;
	logic [2:0]  frac_d;
	logic        point_d, neg_d;

	always_comb begin
		is_num = (tok.field == nga_pkg::FLD_LAT) || (tok.field == nga_pkg::FLD_LON) ||
			(tok.field == nga_pkg::FLD_SATS) || (tok.field == nga_pkg::FLD_ALT);
		if (tok.field == nga_pkg::FLD_LAT || tok.field == nga_pkg::FLD_LON)
			lim = COORD_LIM;
		else if (tok.field == nga_pkg::FLD_ALT)
			lim = ALT_LIM;
		else
			lim = 3'd0;
		is_digit = (tok.data >= nga_pkg::CH_ZERO) && (tok.data <= nga_pkg::CH_NINE);
		dval = tok.data[3:0];
		take_digit = is_digit && !(point_q && frac_q >= lim);
		prod10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {32'd0, dval};
		acc_d = acc_q;
		frac_d = frac_q;
		point_d = point_q;
		neg_d = neg_q;
		case (tok.kind)
			nga_pkg::TK_CHAR: begin
				if (is_num) begin
					if (tok.data == nga_pkg::CH_MINUS && tok.cif == 4'd0) begin
						neg_d = 1'b1;
					end else if (tok.data == nga_pkg::CH_POINT) begin
						point_d = 1'b1;
					end else if (take_digit) begin
						if (acc_q == nga_pkg::ACC_STUCK || prod10[35:32] != 4'd0)
							acc_d = nga_pkg::ACC_STUCK;
						else
							acc_d = prod10[31:0];
						if (point_q)
							frac_d = frac_q + 3'd1;
					end
				end
			end
			default: begin
				acc_d = '0;
				frac_d = '0;
				point_d = 1'b0;
				neg_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			frac_q <= '0;
			point_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (tok_pop) begin
			acc_q <= acc_d;
			frac_q <= frac_d;
			point_q <= point_d;
			neg_q <= neg_d;
		end
	end

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= tok.kind;
			data_s1 <= tok.data;
			field_s1 <= tok.field;
			cif_s1 <= tok.cif;
			acc_s1 <= acc_q;
			frac_s1 <= frac_q;
			neg_s1 <= neg_q;
		end
	end

	// Rescale to the output fraction width.
	logic [2:0]  tgt;
	logic [45:0] mag_d;

	always_comb begin
		tgt = (field_s1 == nga_pkg::FLD_ALT) ? nga_pkg::ALT_OUT : nga_pkg::COORD_OUT;
		if (field_s1 == nga_pkg::FLD_SATS)
			mag_d = {14'd0, acc_s1};
		else if (frac_s1 <= tgt)
			mag_d = {14'd0, acc_s1} * {32'd0, nga_pkg::pow10(tgt - frac_s1)};
		else if (frac_s1 - tgt == 3'd1)
			mag_d = {14'd0, nga_pkg::div10(acc_s1)};
		else
			mag_d = {14'd0, nga_pkg::div100(acc_s1)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			data_s2 <= data_s1;
			field_s2 <= field_s1;
			cif_s2 <= cif_s1;
			mag_s2 <= mag_d;
			stuck_s2 <= (acc_s1 == nga_pkg::ACC_STUCK);
			neg_s2 <= neg_s1;
		end
	end

	// Saturate and update the stored values.
	logic [29:0] coord_v;
	logic [24:0] alt_mag;
	logic        commit;

	always_comb begin
		if (neg_s2)
			coord_v = '0;
		else if (stuck_s2 || mag_s2 > {16'd0, nga_pkg::COORD_MAX})
			coord_v = nga_pkg::COORD_MAX;
		else
			coord_v = mag_s2[29:0];
		if (stuck_s2 || mag_s2 > {21'd0, nga_pkg::ALT_MAX})
			alt_mag = nga_pkg::ALT_MAX;
		else
			alt_mag = mag_s2[24:0];
		commit = (kind_s2 == nga_pkg::TK_COMMIT || kind_s2 == nga_pkg::TK_EMIT) &&
			cif_s2 != 4'd0;
		tdig_d = tdig_q;
		lat_d = lat_q;
		lon_d = lon_q;
		ns_d = ns_q;
		ew_d = ew_q;
		unit_d = unit_q;
		sats_d = sats_q;
		alt_d = alt_q;
		if (kind_s2 == nga_pkg::TK_CHAR) begin
			if (field_s2 == nga_pkg::FLD_TIME) begin
				if (cif_s2 == 4'd0)
					for (int i = 0; i < 6; i++) tdig_d[i] = 4'd0;
				if (cif_s2 < 4'd6)
					tdig_d[cif_s2[2:0]] = (data_s2 >= nga_pkg::CH_ZERO &&
						data_s2 <= nga_pkg::CH_NINE) ? data_s2[3:0] : 4'd0;
			end else if (cif_s2 == 4'd0 && field_s2 == nga_pkg::FLD_NS) begin
				ns_d = data_s2;
			end else if (cif_s2 == 4'd0 && field_s2 == nga_pkg::FLD_EW) begin
				ew_d = data_s2;
			end else if (cif_s2 == 4'd0 && field_s2 == nga_pkg::FLD_UNIT) begin
				unit_d = data_s2 + nga_pkg::UNIT_OFS;
			end
		end else if (commit) begin
			case (field_s2)
				nga_pkg::FLD_LAT: lat_d = coord_v;
				nga_pkg::FLD_LON: lon_d = coord_v;
				nga_pkg::FLD_SATS: begin
					if (neg_s2)
						sats_d = 8'd0;
					else if (mag_s2 > 46'd255)
						sats_d = 8'd255;
					else
						sats_d = mag_s2[7:0];
				end
				nga_pkg::FLD_ALT: alt_d = neg_s2 ? 25'd0 - alt_mag : alt_mag;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) tdig_q[i] <= 4'd0;
			lat_q <= '0;
			lon_q <= '0;
			ns_q <= nga_pkg::CH_SPACE;
			ew_q <= nga_pkg::CH_SPACE;
			unit_q <= nga_pkg::CH_SPACE;
			sats_q <= '0;
			alt_q <= '0;
		end else if (adv && v_s2) begin
			tdig_q <= tdig_d;
			lat_q <= lat_d;
			lon_q <= lon_d;
			ns_q <= ns_d;
			ew_q <= ew_d;
			unit_q <= unit_d;
			sats_q <= sats_d;
			alt_q <= alt_d;
		end
	end

	// Output register.
	logic emit;
	assign emit = adv && v_s2 && kind_s2 == nga_pkg::TK_EMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (fix.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			fix.utc_hour <= 7'(tdig_d[0]) * 7'd10 + 7'(tdig_d[1]);
			fix.utc_minute <= 7'(tdig_d[2]) * 7'd10 + 7'(tdig_d[3]);
			fix.utc_second <= 7'(tdig_d[4]) * 7'd10 + 7'(tdig_d[5]);
			fix.latitude_scaled <= lat_d;
			fix.lat_hemisphere <= ns_d;
			fix.longitude_scaled <= lon_d;
			fix.lon_hemisphere <= ew_d;
			fix.satellite_count <= sats_d;
			fix.altitude_tenths <= alt_d;
			fix.altitude_unit <= unit_d;
		end
	end

	assign fix.valid = out_v_q;

endmodule

>>> src/nmea_gga_field_parser.sv
// NMEA GGA field parser.
// The rx channel takes one character of the serial stream per word. A
// sentence that begins with "$GPGGA," is parsed field by field; when the CR
// or LF that ends it arrives, one word on the fix channel carries the time
// digits, latitude and longitude (units of 1e-6 after division by 100),
// hemisphere letters, satellite count, altitude in tenths and the unit
// letter. Other sentences produce nothing.
// Throughput is one character per cycle while the queue is not full. After
// its line-end character is taken, a result passes through the word queue,
// the stage-one snapshot register, the rescaling multiplier into the
// stage-two register and saturation into the output register.
// When the fix receiver stalls, the back pipeline holds, the queue fills and
// rx.ready falls once the queue is full; nothing is dropped.
// Reset clears the sentence tracking, the accumulator, all stored numbers
// to zero and the three stored letters to the space character.
module nmea_gga_field_parser #(
	parameter int COORD_FRAC_DIGITS = 4,
	parameter int ALT_FRAC_DIGITS = 1,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	nga_byte_if.sink  rx,
	nga_fix_if.source fix
);

	logic            tok_push, tok_full, tok_valid, tok_pop;
	nga_pkg::token_t tok_in, tok_out;

	nga_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.tok_full (tok_full),
		.tok_push (tok_push),
		.tok      (tok_in)
	);

	nga_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.wdata  (tok_in),
		.full   (tok_full),
		.pop    (tok_pop),
		.valid  (tok_valid),
		.rdata  (tok_out)
	);

	nga_back #(
		.COORD_FRAC_DIGITS (COORD_FRAC_DIGITS),
		.ALT_FRAC_DIGITS   (ALT_FRAC_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok_out),
		.tok_pop   (tok_pop),
		.fix       (fix)
	);

endmodule
